/* hdl/base64_codec_core_defines.svh */
// Assertion macros for the base64 codec.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef BASE64_CODEC_CORE_DEFINES_SVH
`define BASE64_CODEC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Plain invariant, checked on every rising clock edge outside reset
`define B64_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("base64 codec assertion failed");
// Same-cycle implication
`define B64_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("base64 codec assertion failed");
// Next-cycle implication
`define B64_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("base64 codec assertion failed");
`else
`define B64_ASSERT(lbl, expr)
`define B64_ASSERT_IMP(lbl, ante, cons)
`define B64_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/b64_pkg.sv */
`timescale 1ns / 1ps
package b64_pkg;

   // mode register codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='
   localparam logic [5:0] SIX_MASK = 6'h3F;

   // results one input item can cause at most
   localparam int MAX_RESULTS = 4;
   // default depth of the command queue between front and back
   localparam int CMD_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] value_out;
      logic       has_data;
      logic       run_last;
      logic       message_end;
   } rsp_type;

   // one classified input item: a short list of result values
   typedef struct packed {
      logic [2:0]                   cnt;       // results in this command, 1..4
      logic [MAX_RESULTS-1:0][7:0]  val;
      logic                         has_data;  // 0 only for the end marker
      logic                         last;      // item closed the message
   } cmd_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] six;
   } dec_type;

   // 6-bit group to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] idx);
      logic [7:0] c;
      c = 8'(idx);
      if (idx < 6'd26)
         return c + 8'd65;      // A..Z
      else if (idx < 6'd52)
         return c + 8'd71;      // a..z
      else if (idx < 6'd62)
         return c - 8'd4;       // 0..9
      else if (idx == 6'd62)
         return 8'h2B;          // '+'
      else
         return 8'h2F;          // '/'
   endfunction

   // alphabet character to 6-bit group; ok low for anything else
   function automatic dec_type dec_char(input logic [7:0] c);
      dec_type d;
      d.ok  = 1'b1;
      d.six = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A)
         d.six = 6'(c - 8'd65);
      else if (c >= 8'h61 && c <= 8'h7A)
         d.six = 6'(c - 8'd71);
      else if (c >= 8'h30 && c <= 8'h39)
         d.six = 6'(c + 8'd4);
      else if (c == 8'h2B)
         d.six = 6'd62;
      else if (c == 8'h2F)
         d.six = 6'd63;
      else
         d.ok = 1'b0;
      return d;
   endfunction

endpackage

/* hdl/b64_front.sv */
`timescale 1ns / 1ps
`include "base64_codec_core_defines.svh"
module b64_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              accept,
   input  b64_pkg::req_type  req,
   output logic              cmd_push,
   output b64_pkg::cmd_type  cmd
);

   logic        mode_ff, mode_in;
   logic [11:0] acc_ff, acc_in;
   logic [2:0]  pend_ff, pend_in;
   logic        pad_ff, pad_in;
   logic [1:0]  cnt4_ff, cnt4_in;

   // encode path
   logic [19:0] wide_e;
   logic [3:0]  p_e;
   logic        two_e;
   logic [2:0]  npend_e;
   logic [11:0] acc_e;
   logic        flush_e;
   logic [5:0]  flush_ch;
   logic [2:0]  nmain;
   logic [1:0]  mod_a;
   logic [1:0]  pads;
   logic [1:0][5:0] main_ch;

   // decode path
   b64_pkg::dec_type dec;
   logic        is_pad;
   logic        take_d;
   logic [17:0] wide_d;
   logic [3:0]  p_d;
   logic        emit_d;

   b64_pkg::cmd_type cmd_e, cmd_d;

   // encode: shift one byte in, emit full groups, flush and pad at the end
   always_comb begin
      wide_e   = {acc_ff[11:0], req.data_in};
      p_e      = {1'b0, pend_ff} + 4'd8;
      two_e    = (p_e == 4'd12);
      main_ch[0] = 6'(wide_e >> (p_e - 4'd6)) & b64_pkg::SIX_MASK;
      main_ch[1] = wide_e[5:0];
      npend_e  = two_e ? 3'd0 : 3'(p_e - 4'd6);
      acc_e    = wide_e[11:0];
      nmain    = two_e ? 3'd2 : 3'd1;
      flush_e  = req.last_in && (npend_e != 3'd0);
      flush_ch = 6'(acc_e << (3'd6 - npend_e));
      mod_a    = cnt4_ff + nmain[1:0] + {1'b0, flush_e};
      pads     = req.last_in ? (2'd0 - mod_a) : 2'd0;
      cmd_e.cnt      = nmain + {2'b0, flush_e} + {1'b0, pads};
      cmd_e.has_data = 1'b1;
      cmd_e.last     = req.last_in;
      for (int k = 0; k < b64_pkg::MAX_RESULTS; k++) begin
         if (3'(k) < nmain)
            cmd_e.val[k] = b64_pkg::enc_char(main_ch[k[0]]);
         else if (3'(k) == nmain && flush_e)
            cmd_e.val[k] = b64_pkg::enc_char(flush_ch);
         else
            cmd_e.val[k] = b64_pkg::PAD_CHAR;
      end
   end

   // decode: skip invalid characters, stop at the first pad
   always_comb begin
      dec    = b64_pkg::dec_char(req.data_in);
      is_pad = (req.data_in == b64_pkg::PAD_CHAR);
      take_d = !pad_ff && !is_pad && dec.ok;
      wide_d = {acc_ff, dec.six};
      p_d    = {1'b0, pend_ff} + 4'd6;
      emit_d = take_d && (p_d >= 4'd8);
      cmd_d.cnt      = (emit_d || req.last_in) ? 3'd1 : 3'd0;
      cmd_d.has_data = emit_d;
      cmd_d.last     = req.last_in;
      cmd_d.val      = '0;
      if (emit_d)
         cmd_d.val[0] = 8'(wide_d >> (p_d - 4'd8));
   end

   assign cmd      = (mode_ff == b64_pkg::MODE_DECODE) ? cmd_d : cmd_e;
   assign cmd_push = accept && (cmd.cnt != 3'd0);

   // codec state update
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      pad_in  = pad_ff;
      cnt4_in = cnt4_ff;
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         acc_in  = '0;
         pend_in = '0;
         pad_in  = 1'b0;
         cnt4_in = '0;
      end else if (accept) begin
         if (req.last_in) begin
            acc_in  = '0;
            pend_in = '0;
            pad_in  = 1'b0;
            cnt4_in = '0;
         end else if (mode_ff == b64_pkg::MODE_DECODE) begin
            if (!pad_ff && is_pad)
               pad_in = 1'b1;
            if (take_d) begin
               acc_in  = wide_d[11:0];
               pend_in = emit_d ? 3'(p_d - 4'd8) : 3'(p_d);
            end
         end else begin
            acc_in  = acc_e;
            pend_in = npend_e;
            cnt4_in = cnt4_ff + nmain[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= b64_pkg::MODE_ENCODE;
         acc_ff  <= '0;
         pend_ff <= '0;
         pad_ff  <= 1'b0;
         cnt4_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         pad_ff  <= pad_in;
         cnt4_ff <= cnt4_in;
      end
   end

   // encode keeps 0, 2 or 4 bits pending
   `B64_ASSERT_IMP(a_enc_pend, mode_ff == b64_pkg::MODE_ENCODE, !pend_ff[0] && pend_ff != 3'd6)
   // a last item always produces at least one result
   `B64_ASSERT_IMP(a_last_pushes, accept && req.last_in, cmd_push)

endmodule

/* hdl/b64_cmd_fifo.sv */
`timescale 1ns / 1ps
`include "base64_codec_core_defines.svh"
module b64_cmd_fifo #(
   parameter int DEPTH = b64_pkg::CMD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output b64_pkg::cmd_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   b64_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_cmd;
   end

   `B64_ASSERT_IMP(a_no_overflow, push, !full || pop)
   `B64_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

/* hdl/b64_back.sv */
`timescale 1ns / 1ps
`include "base64_codec_core_defines.svh"
module b64_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  b64_pkg::cmd_type  head,
   output logic              cmd_pop,
   input  logic              pop,
   output logic              empty,
   output b64_pkg::rsp_type  rsp
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   b64_pkg::rsp_type  rsp_ff, rsp_in;
   logic              load;
   logic              at_end;

   // walk the head command one result per cycle into the output register while it is free or popped
   always_comb begin
      load     = !cmd_empty && (!valid_ff || pop);
      at_end   = ({1'b0, idx_ff} + 3'd1 == head.cnt);
      cmd_pop  = load && at_end;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      valid_in = valid_ff && !pop;
      if (load) begin
         idx_in             = at_end ? 2'd0 : idx_ff + 2'd1;
         rsp_in.value_out   = head.val[idx_ff];
         rsp_in.has_data    = head.has_data;
         rsp_in.run_last    = at_end;
         rsp_in.message_end = at_end && head.last;
         valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign empty = !valid_ff;
   assign rsp   = rsp_ff;

   // the walk never runs past the command's result count
   `B64_ASSERT_IMP(a_idx_range, !cmd_empty, {1'b0, idx_ff} < head.cnt)

endmodule

/* hdl/base64_codec_core.sv */
`timescale 1ns / 1ps
// An item's first result is held in a command queue slot, then in the output register
// before it reaches rsp_data. One item per cycle in while full is low; an encode item
// with n results holds the back end until all n are out (avg. 4 results per 3 bytes).
// The output sets the pace: queued results leave one per cycle while pop is high.
// Reset (synchronous): mode to encode, codec state and queue cleared, output empty.
module base64_codec_core #(
   parameter int CMD_DEPTH = b64_pkg::CMD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              push,
   output logic              full,
   input  b64_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output b64_pkg::rsp_type  rsp_data
);

   logic             accept;
   logic             cmd_push;
   logic             cmd_pop;
   logic             cmd_empty;
   b64_pkg::cmd_type cmd;
   b64_pkg::cmd_type head;

   assign accept = push && !full;

   // front: track codec state, turn each item into a command
   b64_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_data),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   // queue of commands between front and back
   b64_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (cmd_pop),
      .full     (full),
      .empty    (cmd_empty),
      .head     (head)
   );

   // back: emit results one transfer at a time
   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .head      (head),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp_data)
   );

endmodule

/* tb/tb_base64_codec_core.sv */
`timescale 1ns / 1ps
module tb_base64_codec_core;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 51;
   localparam int SETTLE_CYC   = 8;
   localparam int HOLD_CYC     = 300;
   localparam int SHOW_MAX     = 10;
   localparam logic [511:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // how a directed row gets its expectation
   typedef enum logic [1:0] {ROW_PREDICT, ROW_CHARS, ROW_MARKER, ROW_NOTHING} row_kind_type;

   typedef struct packed {
      logic         mode;
      logic [7:0]   data;
      logic         last;
      row_kind_type kind;
      logic [2:0]   n;       // count of literal values
      logic [31:0]  chars;   // literal values, last one in the low byte
   } plan_row_type;

   localparam int PLAN_ROWS = 25;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // encode: single bytes, extremes, padding, a full group
      '{b64_pkg::MODE_ENCODE, 8'h4D, 1'b1, ROW_CHARS,   3'd4, "TQ=="},
      '{b64_pkg::MODE_ENCODE, 8'h00, 1'b0, ROW_CHARS,   3'd1, "A"},
      '{b64_pkg::MODE_ENCODE, 8'hFF, 1'b0, ROW_CHARS,   3'd1, "P"},
      '{b64_pkg::MODE_ENCODE, 8'hFF, 1'b1, ROW_CHARS,   3'd2, "//"},
      '{b64_pkg::MODE_ENCODE, 8'hFF, 1'b1, ROW_CHARS,   3'd4, "/w=="},
      '{b64_pkg::MODE_ENCODE, "M",   1'b0, ROW_PREDICT, 3'd0, 32'h0},
      '{b64_pkg::MODE_ENCODE, "a",   1'b0, ROW_PREDICT, 3'd0, 32'h0},
      '{b64_pkg::MODE_ENCODE, "n",   1'b1, ROW_PREDICT, 3'd0, 32'h0},
      '{b64_pkg::MODE_ENCODE, 8'h80, 1'b1, ROW_CHARS,   3'd4, "gA=="},
      '{b64_pkg::MODE_ENCODE, 8'h7F, 1'b1, ROW_PREDICT, 3'd0, 32'h0},
      // decode: no byte yet, byte, pad stops decoding, end markers
      '{b64_pkg::MODE_DECODE, "T",   1'b0, ROW_NOTHING, 3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "Q",   1'b0, ROW_CHARS,   3'd1, "M"},
      '{b64_pkg::MODE_DECODE, "=",   1'b0, ROW_NOTHING, 3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "A",   1'b1, ROW_MARKER,  3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "!",   1'b1, ROW_MARKER,  3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "/",   1'b0, ROW_NOTHING, 3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "/",   1'b0, ROW_CHARS,   3'd1, 32'hFF},
      '{b64_pkg::MODE_DECODE, 8'h00, 1'b0, ROW_NOTHING, 3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, 8'hFF, 1'b1, ROW_MARKER,  3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "+",   1'b0, ROW_PREDICT, 3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "z",   1'b0, ROW_PREDICT, 3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "9",   1'b1, ROW_PREDICT, 3'd0, 32'h0},
      '{b64_pkg::MODE_DECODE, "a",   1'b1, ROW_MARKER,  3'd0, 32'h0},
      // back to encode; the open message is cut off by the next mode write
      '{b64_pkg::MODE_ENCODE, 8'h55, 1'b1, ROW_PREDICT, 3'd0, 32'h0},
      '{b64_pkg::MODE_ENCODE, 8'hAA, 1'b0, ROW_PREDICT, 3'd0, 32'h0}
   };

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic             csr_wr_data;
   logic             push;
   logic             full;
   b64_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   b64_pkg::rsp_type rsp_data;

   // predictor state
   logic        cur_mode;
   logic [11:0] bit_acc;
   logic [2:0]  bits_held;
   logic        pad_hit;
   logic [1:0]  chars_mod4;

   b64_pkg::rsp_type codec_out_q [$];
   int      mismatches;
   int      cycles;
   bit      quiet;
   bit      hold_req;

   base64_codec_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("base64_codec_core regression: fail");
         $finish;
      end
   end

   function automatic void wipe_codec();
      bit_acc    = '0;
      bits_held  = '0;
      pad_hit    = 1'b0;
      chars_mod4 = '0;
   endfunction

   function automatic logic [7:0] alpha_at(input int idx);
      return ALPHABET[8*(63-idx) +: 8];
   endfunction

   // queue one awaited result
   function automatic void add_want(input b64_pkg::rsp_type r);
      codec_out_q.insert(codec_out_q.size(), r);
   endfunction

   // one base64 step: returns the number of results, fills res
   function automatic int base64_step(input logic [7:0] c, input logic last,
                                      output b64_pkg::rsp_type res [b64_pkg::MAX_RESULTS]);
      int   wide;
      int   p;
      int   n;
      int   v;
      int   i;
      logic found;
      n = 0;
      for (i = 0; i < b64_pkg::MAX_RESULTS; i++)
         res[i] = '0;
      if (cur_mode == b64_pkg::MODE_ENCODE) begin
         wide = (int'(bit_acc) << 8) | int'(c);
         p = int'(bits_held) + 8;
         while (p >= 6) begin
            res[n] = '{value_out: alpha_at((wide >> (p - 6)) & 63), has_data: 1'b1,
                       run_last: 1'b0, message_end: 1'b0};
            n++;
            chars_mod4++;
            p -= 6;
         end
         bit_acc   = wide[11:0];
         bits_held = p[2:0];
         if (last) begin
            // flush leftover bits, zero filled
            if (bits_held > 0 && bits_held < 6) begin
               res[n] = '{value_out: alpha_at((int'(bit_acc) << (6 - bits_held)) & 63),
                          has_data: 1'b1, run_last: 1'b0, message_end: 1'b0};
               n++;
               chars_mod4++;
            end
            // pad to a multiple of four characters
            while (chars_mod4 != 0 && n < b64_pkg::MAX_RESULTS) begin
               res[n] = '{value_out: b64_pkg::PAD_CHAR, has_data: 1'b1, run_last: 1'b0,
                          message_end: 1'b0};
               n++;
               chars_mod4++;
            end
         end
      end else begin
         if (!pad_hit) begin
            if (c == b64_pkg::PAD_CHAR) begin
               pad_hit = 1'b1;
            end else begin
               found = 1'b0;
               v = 0;
               for (i = 0; i < 64; i++)
                  if (!found && alpha_at(i) == c) begin
                     found = 1'b1;
                     v = i;
                  end
               // characters outside the alphabet are skipped
               if (found) begin
                  wide = (int'(bit_acc) << 6) | v;
                  p = int'(bits_held) + 6;
                  if (p >= 8) begin
                     res[n] = '{value_out: 8'((wide >> (p - 8)) & 255), has_data: 1'b1,
                                run_last: 1'b0, message_end: 1'b0};
                     n++;
                     p -= 8;
                  end
                  bit_acc   = wide[11:0];
                  bits_held = p[2:0];
               end
            end
         end
         // end marker when the last item gives no byte
         if (last && n == 0) begin
            res[0] = '0;
            n = 1;
         end
      end
      if (n > 0) begin
         res[n-1].run_last = 1'b1;
         if (last)
            res[n-1].message_end = 1'b1;
      end
      if (last)
         wipe_codec();
      return n;
   endfunction

   // drop push, wait for every awaited result, then let the block go quiet
   task automatic settle();
      push <= 1'b0;
      do @(posedge clock); while (codec_out_q.size() > 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_wr_data <= m;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
      wipe_codec();
   endtask

   // send one item; after its transfer queue what it should produce
   task automatic apply_item(input logic [7:0] c, input logic last, input row_kind_type kind,
                             input logic [2:0] lit_n, input logic [31:0] lit);
      int      gap;
      int      cnt;
      int      k;
      b64_pkg::rsp_type res [b64_pkg::MAX_RESULTS];
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{data_in: c, last_in: last};
      push     <= 1'b1;
      do @(posedge clock); while (full);
      cnt = base64_step(c, last, res);
      case (kind)
         ROW_PREDICT: begin
            for (k = 0; k < cnt; k++)
               add_want(res[k]);
         end
         ROW_CHARS: begin
            for (k = 0; k < lit_n; k++)
               add_want('{value_out: lit[8*(lit_n-1-k) +: 8], has_data: 1'b1,
                          run_last: (k == lit_n - 1),
                          message_end: last && (k == lit_n - 1)});
         end
         ROW_MARKER: begin
            add_want('{value_out: 8'h00, has_data: 1'b0, run_last: 1'b1,
                       message_end: 1'b1});
         end
         default: ;
      endcase
   endtask

   // result side: random pops, one long hold-off on request
   initial begin
      b64_pkg::rsp_type got;
      b64_pkg::rsp_type want;
      int      gap;
      bit      held;
      held = 1'b0;
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_req && !held) begin
            held = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYC) @(posedge clock);
         end
         gap = quiet ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got = rsp_data;
         if (codec_out_q.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
               $display("unexpected transfer: value=%h has_data=%b run_last=%b end=%b",
                        got.value_out, got.has_data, got.run_last, got.message_end);
         end else begin
            want = codec_out_q.pop_front();
            if (got.value_out !== want.value_out || got.has_data !== want.has_data ||
                got.run_last !== want.run_last || got.message_end !== want.message_end) begin
               mismatches++;
               if (mismatches <= SHOW_MAX)
                  $display("mismatch: value %h/%h has_data %b/%b run_last %b/%b end %b/%b",
                           want.value_out, got.value_out, want.has_data, got.has_data,
                           want.run_last, got.run_last, want.message_end, got.message_end);
            end
         end
      end
   end

   // stimulus
   initial begin
      int         ph;
      int         sent;
      int         len;
      int         k;
      int         pick;
      bit         open_end;
      bit         cut;
      bit         paused;
      logic [7:0] c;
      logic       last;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      push        <= 1'b0;
      req_data    <= '0;
      quiet       = 1'b0;
      hold_req    = 1'b0;
      cur_mode    = b64_pkg::MODE_ENCODE;
      wipe_codec();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (k = 0; k < PLAN_ROWS; k++) begin
         if (PLAN[k].mode != cur_mode) begin
            settle();
            write_mode(PLAN[k].mode);
         end
         apply_item(PLAN[k].data, PLAN[k].last, PLAN[k].kind, PLAN[k].n, PLAN[k].chars);
      end

      // random phases, one mode setting each
      paused = 1'b0;
      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph == 0)
            write_mode(b64_pkg::MODE_DECODE);
         else if (ph == 1)
            write_mode(b64_pkg::MODE_ENCODE);
         else
            write_mode(1'($urandom_range(0, 1)));
         quiet    = (ph == 3);
         hold_req = (ph == 1);
         open_end = (ph % 3 == 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 8);
            if (sent + len > PHASE_ITEMS)
               len = PHASE_ITEMS - sent;
            cut = open_end && (sent + len >= PHASE_ITEMS);
            for (k = 0; k < len; k++) begin
               if (cur_mode == b64_pkg::MODE_ENCODE) begin
                  c = 8'($urandom_range(0, 255));
               end else begin
                  // mostly alphabet characters, some pads and junk
                  pick = $urandom_range(0, 99);
                  if (pick < 78)
                     c = alpha_at($urandom_range(0, 63));
                  else if (pick < 84)
                     c = b64_pkg::PAD_CHAR;
                  else
                     c = 8'($urandom_range(0, 255));
               end
               last = (k == len - 1) && !cut;
               apply_item(c, last, ROW_PREDICT, 3'd0, 32'h0);
               sent++;
               // sender waits once for the result side to drain
               if (ph == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
                  paused = 1'b1;
                  settle();
               end
            end
         end
      end
      quiet = 1'b0;

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && codec_out_q.size() == 0)
         $display("base64_codec_core regression: pass");
      else
         $display("base64_codec_core regression: fail");
      $finish;
   end

endmodule
